/* rtl/core/kps_pkg.sv */
package kps_pkg;

  // coordinate format, signed, fraction position does not affect the arithmetic
  localparam int COORD_BITS = 32;

  // segment delta and its third
  localparam int T_BITS = COORD_BITS + 1;

  // divide by three: n = nh * 2^16 + nl, and 2^16 = 3 * 21845 + 1
  localparam int SPLIT_BITS   = 16;
  localparam int NH_BITS      = T_BITS - SPLIT_BITS;
  localparam int S_BITS       = NH_BITS + 1;
  localparam int HI_MUL_BITS  = 15;
  localparam int DIV3_HI_MUL  = 21845;
  localparam int RECIP_BITS   = 19;
  localparam int DIV3_RECIP   = 349526;
  localparam int DIV3_SHIFT   = 20;
  localparam int PH_BITS      = NH_BITS + HI_MUL_BITS;
  localparam int PL_BITS      = S_BITS + RECIP_BITS;

  // rotation by +60 degrees, cos = 1/2 and sin = sqrt(3)/2 in Q0.16
  localparam int SIN_BITS   = 17;
  localparam int SIN60_Q16  = 56756;
  localparam int Q_FRAC     = 16;
  localparam int COS_SHIFT  = Q_FRAC - 1;
  localparam int HALF_Q16   = 32768;
  localparam int PROD_BITS  = T_BITS + SIN_BITS;
  localparam int ROT_BITS   = PROD_BITS - Q_FRAC;

  // headroom for sums before saturation
  localparam int WIDE_BITS = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [T_BITS-1:0]     delta_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [1:0]                   slot_t;

  localparam slot_t SLOT_FIRST = 2'd0;
  localparam slot_t SLOT_LAST  = 2'd3;

  // segment command from the front end
  typedef struct packed {
    logic   first;
    coord_t x;
    coord_t y;
    coord_t px;
    coord_t py;
    delta_t dx;
    delta_t dy;
  } kps_cmd_t;

  // one emitted vertex
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   end_of_run;
  } kps_res_t;

  function automatic coord_t sat_coord(input wide_t v);
    wide_t  hi;
    wide_t  lo;
    coord_t r;
    hi = {{(WIDE_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      r = lo[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/kps_fifo.sv */
module kps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/kps_front.sv */
module kps_front import kps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     in_first_vertex,
  input  coord_t   in_x_coord,
  input  coord_t   in_y_coord,
  input  logic     cmd_full,
  output logic     cmd_push,
  output kps_cmd_t cmd_data
);

  logic   have_prev_r, have_prev_nxt;
  coord_t prev_x_r, prev_x_nxt;
  coord_t prev_y_r, prev_y_nxt;

  assign cmd_push = push && !cmd_full;

  always_comb begin
    // no kept vertex means this one starts a line
    cmd_data.first = in_first_vertex || !have_prev_r;
    cmd_data.x     = in_x_coord;
    cmd_data.y     = in_y_coord;
    cmd_data.px    = prev_x_r;
    cmd_data.py    = prev_y_r;
    cmd_data.dx    = T_BITS'(in_x_coord) - T_BITS'(prev_x_r);
    cmd_data.dy    = T_BITS'(in_y_coord) - T_BITS'(prev_y_r);

    have_prev_nxt = have_prev_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    if (cmd_push) begin
      have_prev_nxt = 1'b1;
      prev_x_nxt    = in_x_coord;
      prev_y_nxt    = in_y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      have_prev_r <= have_prev_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
    end
  end

endmodule

/* rtl/core/kps_back.sv */
module kps_back import kps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_empty,
  input  kps_cmd_t cmd_data,
  output logic     cmd_pop,
  input  logic     res_full,
  output logic     res_push,
  output kps_res_t res_data
);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, bv_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic emit, done;

  // stage 1: magnitude plus one, split for the divide
  kps_cmd_t           c1_r;
  logic [NH_BITS-1:0] nhx1_r, nhy1_r, nhx1_nxt, nhy1_nxt;
  logic [S_BITS-1:0]  sx1_r, sy1_r, sx1_nxt, sy1_nxt;
  logic               negx1_r, negy1_r;
  logic [T_BITS-1:0]  nx, ny;

  // stage 2: quotient magnitude
  kps_cmd_t              c2_r;
  logic [COORD_BITS-1:0] qx2_r, qy2_r, qx2_nxt, qy2_nxt;
  logic                  negx2_r, negy2_r;
  logic [PH_BITS-1:0]    phx, phy;
  logic [PL_BITS-1:0]    plx, ply;

  // stage 3: signed third of the segment
  kps_cmd_t c3_r;
  delta_t   tx3_r, ty3_r, tx3_nxt, ty3_nxt;

  // stage 4: rotation products and one/two-thirds points
  kps_cmd_t                     c4_r;
  delta_t                       tx4_r, ty4_r;
  logic signed [PROD_BITS-1:0]  mx4_r, my4_r, mx4_nxt, my4_nxt;
  wide_t                        ax4_r, ay4_r, cx4_r, cy4_r;
  wide_t                        ax4_nxt, ay4_nxt, cx4_nxt, cy4_nxt;

  // stage 5: rounded rotation
  kps_cmd_t                     c5_r;
  wide_t                        ax5_r, ay5_r, cx5_r, cy5_r;
  logic signed [ROT_BITS-1:0]   rx5_r, ry5_r;
  logic signed [PROD_BITS-1:0]  lx, ly;

  // stage 6: result bundle, emitted one slot per cycle while the result queue has room
  coord_t pt_x_r [4];
  coord_t pt_y_r [4];
  slot_t  idx_r, idx_nxt;

  assign emit = bv_r && !res_full;
  assign done = emit && (idx_r == SLOT_LAST);
  assign rdy6 = !bv_r || done;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign cmd_pop = rdy1 && !cmd_empty;

  assign res_push            = emit;
  assign res_data.x          = pt_x_r[idx_r];
  assign res_data.y          = pt_y_r[idx_r];
  assign res_data.end_of_run = (idx_r == SLOT_LAST);

  always_comb begin
    // |d| + 1
    nx = cmd_data.dx[T_BITS-1] ? (~cmd_data.dx + T_BITS'(2)) : (cmd_data.dx + T_BITS'(1));
    ny = cmd_data.dy[T_BITS-1] ? (~cmd_data.dy + T_BITS'(2)) : (cmd_data.dy + T_BITS'(1));
    nhx1_nxt = nx[T_BITS-1:SPLIT_BITS];
    nhy1_nxt = ny[T_BITS-1:SPLIT_BITS];
    sx1_nxt  = S_BITS'(nhx1_nxt) + S_BITS'(nx[SPLIT_BITS-1:0]);
    sy1_nxt  = S_BITS'(nhy1_nxt) + S_BITS'(ny[SPLIT_BITS-1:0]);

    // floor(n/3) = nh * 21845 + floor((nh + nl) / 3)
    phx = {{HI_MUL_BITS{1'b0}}, nhx1_r} * PH_BITS'(DIV3_HI_MUL);
    phy = {{HI_MUL_BITS{1'b0}}, nhy1_r} * PH_BITS'(DIV3_HI_MUL);
    plx = {{RECIP_BITS{1'b0}}, sx1_r} * PL_BITS'(DIV3_RECIP);
    ply = {{RECIP_BITS{1'b0}}, sy1_r} * PL_BITS'(DIV3_RECIP);
    qx2_nxt = COORD_BITS'(phx) + COORD_BITS'(plx[PL_BITS-1:DIV3_SHIFT]);
    qy2_nxt = COORD_BITS'(phy) + COORD_BITS'(ply[PL_BITS-1:DIV3_SHIFT]);

    tx3_nxt = negx2_r ? -$signed({1'b0, qx2_r}) : $signed({1'b0, qx2_r});
    ty3_nxt = negy2_r ? -$signed({1'b0, qy2_r}) : $signed({1'b0, qy2_r});

    mx4_nxt = PROD_BITS'(tx3_r) * PROD_BITS'(SIN60_Q16);
    my4_nxt = PROD_BITS'(ty3_r) * PROD_BITS'(SIN60_Q16);
    ax4_nxt = WIDE_BITS'(c3_r.px) + WIDE_BITS'(tx3_r);
    ay4_nxt = WIDE_BITS'(c3_r.py) + WIDE_BITS'(ty3_r);
    cx4_nxt = WIDE_BITS'(c3_r.px) + (WIDE_BITS'(tx3_r) <<< 1);
    cy4_nxt = WIDE_BITS'(c3_r.py) + (WIDE_BITS'(ty3_r) <<< 1);

    // round to nearest, ties upward
    lx = (PROD_BITS'(tx4_r) <<< COS_SHIFT) - my4_r + PROD_BITS'(HALF_Q16);
    ly = (PROD_BITS'(ty4_r) <<< COS_SHIFT) + mx4_r + PROD_BITS'(HALF_Q16);

    idx_nxt = idx_r;
    if (rdy6) begin
      idx_nxt = c5_r.first ? SLOT_LAST : SLOT_FIRST;
    end else if (emit) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      bv_r  <= 1'b0;
      idx_r <= SLOT_FIRST;
    end else begin
      if (rdy1) begin
        v1_r <= !cmd_empty;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        bv_r <= v5_r;
      end
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c1_r    <= cmd_data;
      nhx1_r  <= nhx1_nxt;
      nhy1_r  <= nhy1_nxt;
      sx1_r   <= sx1_nxt;
      sy1_r   <= sy1_nxt;
      negx1_r <= cmd_data.dx[T_BITS-1];
      negy1_r <= cmd_data.dy[T_BITS-1];
    end
    if (rdy2 && v1_r) begin
      c2_r    <= c1_r;
      qx2_r   <= qx2_nxt;
      qy2_r   <= qy2_nxt;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
    end
    if (rdy3 && v2_r) begin
      c3_r  <= c2_r;
      tx3_r <= tx3_nxt;
      ty3_r <= ty3_nxt;
    end
    if (rdy4 && v3_r) begin
      c4_r  <= c3_r;
      tx4_r <= tx3_r;
      ty4_r <= ty3_r;
      mx4_r <= mx4_nxt;
      my4_r <= my4_nxt;
      ax4_r <= ax4_nxt;
      ay4_r <= ay4_nxt;
      cx4_r <= cx4_nxt;
      cy4_r <= cy4_nxt;
    end
    if (rdy5 && v4_r) begin
      c5_r  <= c4_r;
      ax5_r <= ax4_r;
      ay5_r <= ay4_r;
      cx5_r <= cx4_r;
      cy5_r <= cy4_r;
      rx5_r <= lx[PROD_BITS-1:Q_FRAC];
      ry5_r <= ly[PROD_BITS-1:Q_FRAC];
    end
    if (rdy6 && v5_r) begin
      pt_x_r[0] <= sat_coord(ax5_r);
      pt_y_r[0] <= sat_coord(ay5_r);
      pt_x_r[1] <= sat_coord(ax5_r + WIDE_BITS'(rx5_r));
      pt_y_r[1] <= sat_coord(ay5_r + WIDE_BITS'(ry5_r));
      pt_x_r[2] <= sat_coord(cx5_r);
      pt_y_r[2] <= sat_coord(cy5_r);
      pt_x_r[3] <= c5_r.x;
      pt_y_r[3] <= c5_r.y;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_bundle_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && idx_r != SLOT_LAST) |=> bv_r)
    else $error("bundle dropped before its last slot");

  a_slot_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (bv_r && !emit) |=> $stable(idx_r))
    else $error("slot index moved without a transfer");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> v1_r)
    else $error("command popped but stage one empty");

endmodule

/* rtl/core/koch_polyline_subdivider.sv */
// Koch subdivision step on a stream of polyline vertices (signed Q15.16 x/y).
// The first vertex of a line (in_first_vertex high, or nothing kept since reset)
// comes out alone with out_end_of_run set. Each later vertex closes a segment
// from the kept vertex and yields four results in order: the one-third point,
// the apex of the +60 degree bump, the two-thirds point and the vertex itself,
// the last flagged with out_end_of_run. Thirds round to nearest, the rotation
// rounds to nearest with ties upward, and every coordinate saturates to 32 bits.
// Input vertices are taken one per cycle into a short command queue while it is
// not full; results leave through a small output queue at one per cycle while
// popped and not empty, so a segment vertex yields four results and a first vertex
// one, the single result port being the limit.
module koch_polyline_subdivider import kps_pkg::*; #(
  parameter int CMD_DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  // input queue side
  input  logic   push,
  output logic   full,
  input  logic   in_first_vertex,
  input  coord_t in_x_coord,
  input  coord_t in_y_coord,
  // result queue side
  output logic   empty,
  input  logic   pop,
  output coord_t out_x,
  output coord_t out_y,
  output logic   out_end_of_run
);

  // front end to command queue
  logic     cmd_push;
  kps_cmd_t cmd_wdata;
  logic     cmd_full;

  // command queue to back end
  logic     cmd_pop;
  kps_cmd_t cmd_rdata;
  logic     cmd_empty;

  // back end to result queue
  logic     res_push;
  kps_res_t res_wdata;
  logic     res_full;
  kps_res_t res_rdata;

  assign full = cmd_full;

  // keeps the previous vertex, classifies and takes the segment delta
  kps_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_first_vertex (in_first_vertex),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd_data        (cmd_wdata)
  );

  // decouples vertex intake from result generation
  kps_fifo #(
    .WIDTH ($bits(kps_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wdata),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  // divide, rotate, saturate, then serialize the result bundle
  kps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  // output stage, keeps a waiting result from stalling the back end
  kps_fifo #(
    .WIDTH ($bits(kps_res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wdata),
    .rd_en   (pop && !empty),
    .rd_data (res_rdata),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_x          = res_rdata.x;
  assign out_y          = res_rdata.y;
  assign out_end_of_run = res_rdata.end_of_run;

endmodule
